### src/htct_pkg.sv
// Package: field widths, default parameters and transaction types for the histogram threshold.
package htct_pkg;

	// Default parameter values
	localparam int VALUE_BITS_DEF = 8;
	localparam int COUNT_BITS_DEF = 25;

	// Fixed payload field widths
	localparam int SAMPLE_W    = 8;
	localparam int THRESHOLD_W = 9;
	localparam int CNT_W       = 25;
	localparam int DESIRED_W   = 25;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_value;
		logic                last_sample;
	} in_item_t;

	typedef struct packed {
		logic [THRESHOLD_W-1:0] threshold;
		logic [CNT_W-1:0]       count_at_threshold;
		logic                   short_frame;
	} out_item_t;

endpackage

### src/histogram_top_count_threshold_top.sv
// Histogram threshold: bin memory, read-modify-write update, top-down scan and result register.
//
// Samples of a frame enter at one per cycle while the block is accumulating; each one reads
// its bin from a single synchronous memory of 2^VALUE_BITS entries and writes the saturated
// count back in the next cycle, with forwarding when consecutive samples hit the same bin.
// The sample marked last closes the frame: in_ready then stays low while the block sweeps
// every bin from the top down through the same memory port, summing counts until
// desired_count is reached and writing zero behind itself so the next frame starts clear.
// The result is held in an output register and a new frame may start while it waits; if
// the previous result has not been taken when the sweep ends, in_ready stays low until it
// is. After reset a clearing pass over every bin runs before the first sample is taken;
// cfg_we writes are taken at any time.
module histogram_top_count_threshold_top #(
	parameter int VALUE_BITS = htct_pkg::VALUE_BITS_DEF,
	parameter int COUNT_BITS = htct_pkg::COUNT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [htct_pkg::DESIRED_W-1:0]   cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  htct_pkg::in_item_t               in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output htct_pkg::out_item_t              out_data
);

	localparam int NUM_BINS = 1 << VALUE_BITS;
	localparam int THR_W    = VALUE_BITS + 1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_ACC   = 6'b000010,
		ST_DRAIN = 6'b000100,
		ST_SCAN  = 6'b001000,
		ST_TAIL  = 6'b010000,
		ST_RES   = 6'b100000
	} state_t;

	state_t state_q;

	// Configuration register
	logic [COUNT_BITS-1:0] desired_q;
	logic [htct_pkg::DESIRED_W+COUNT_BITS-1:0] cfg_ext;
	assign cfg_ext = {{COUNT_BITS{1'b0}}, cfg_wdata};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desired_q <= '0;
		end else if (cfg_we) begin
			desired_q <= cfg_ext[COUNT_BITS-1:0];
		end
	end

	// Input transaction and bin index
	logic                  in_fire;
	logic [VALUE_BITS-1:0] in_bin;
	logic [htct_pkg::SAMPLE_W+VALUE_BITS-1:0] samp_ext;

	assign in_ready = (state_q == ST_ACC);
	assign in_fire  = in_valid && in_ready;
	assign samp_ext = {{VALUE_BITS{1'b0}}, in_data.sample_value};
	assign in_bin   = samp_ext[VALUE_BITS-1:0];

	// Bin memory
	logic [COUNT_BITS-1:0] bin_mem [NUM_BINS];
	logic [COUNT_BITS-1:0] mem_rdata_q;
	logic [VALUE_BITS-1:0] mem_raddr;
	logic [VALUE_BITS-1:0] mem_waddr;
	logic [COUNT_BITS-1:0] mem_wdata;
	logic                  mem_we;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			bin_mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= bin_mem[mem_raddr];
	end

	// Sweep address and pipeline tracking
	logic [VALUE_BITS-1:0] scan_addr_q;
	logic                  acc_vld_s1;
	logic [VALUE_BITS-1:0] acc_bin_s1;
	logic                  scan_vld_s1;
	logic [VALUE_BITS-1:0] scan_bin_s1;
	logic                  wr_vld_q;
	logic [VALUE_BITS-1:0] wr_addr_q;
	logic [COUNT_BITS-1:0] wr_data_q;
	logic                  sweeping;

	assign sweeping = (state_q == ST_CLEAR) || (state_q == ST_SCAN);

	// Update path: forward the previous write when it hit the same bin
	logic [COUNT_BITS-1:0] acc_cur;
	logic [COUNT_BITS-1:0] acc_inc;

	assign acc_cur = (wr_vld_q && (wr_addr_q == acc_bin_s1)) ? wr_data_q : mem_rdata_q;
	assign acc_inc = (acc_cur == COUNT_MAX) ? COUNT_MAX : acc_cur + COUNT_BITS'(1);

	// Memory port selection
	always_comb begin
		mem_raddr = sweeping ? scan_addr_q : in_bin;
		mem_we    = 1'b0;
		mem_waddr = scan_addr_q;
		mem_wdata = '0;
		if (sweeping) begin
			mem_we = 1'b1;
		end else if (acc_vld_s1) begin
			mem_we    = 1'b1;
			mem_waddr = acc_bin_s1;
			mem_wdata = acc_inc;
		end
	end

	// Scan accumulation
	logic [COUNT_BITS-1:0] total_q;
	logic [THR_W-1:0]      thr_q;
	logic [COUNT_BITS:0]   total_sum;
	logic [COUNT_BITS-1:0] total_sat;
	logic                  reached;

	assign reached   = (total_q >= desired_q);
	assign total_sum = {1'b0, total_q} + {1'b0, mem_rdata_q};
	assign total_sat = total_sum[COUNT_BITS] ? COUNT_MAX : total_sum[COUNT_BITS-1:0];

	always_ff @(posedge clk) begin
		if (state_q == ST_DRAIN) begin
			total_q <= '0;
			thr_q   <= THR_W'(NUM_BINS);
		end else if (scan_vld_s1 && !reached) begin
			total_q <= total_sat;
			thr_q   <= {1'b0, scan_bin_s1};
		end
	end

	// Result formatting
	logic [THR_W+htct_pkg::THRESHOLD_W-1:0] thr_ext;
	logic [COUNT_BITS+htct_pkg::CNT_W-1:0]  cnt_ext;
	logic                                   res_load;

	assign thr_ext  = {{htct_pkg::THRESHOLD_W{1'b0}}, thr_q};
	assign cnt_ext  = {{htct_pkg::CNT_W{1'b0}}, total_q};
	assign res_load = (state_q == ST_RES) && (!out_valid || out_ready);

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_data.threshold          <= thr_ext[htct_pkg::THRESHOLD_W-1:0];
			out_data.count_at_threshold <= cnt_ext[htct_pkg::CNT_W-1:0];
			out_data.short_frame        <= !reached;
		end
	end

	// Pipeline payload registers
	always_ff @(posedge clk) begin
		acc_bin_s1  <= in_bin;
		scan_bin_s1 <= scan_addr_q;
		wr_addr_q   <= mem_waddr;
		wr_data_q   <= mem_wdata;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			scan_addr_q <= '1;
			acc_vld_s1  <= 1'b0;
			scan_vld_s1 <= 1'b0;
			wr_vld_q    <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			acc_vld_s1  <= in_fire;
			scan_vld_s1 <= (state_q == ST_SCAN);
			wr_vld_q    <= mem_we;
			if (res_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					scan_addr_q <= scan_addr_q - VALUE_BITS'(1);
					if (scan_addr_q == '0) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (in_fire && in_data.last_sample) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					scan_addr_q <= '1;
					state_q     <= ST_SCAN;
				end
				ST_SCAN: begin
					scan_addr_q <= scan_addr_q - VALUE_BITS'(1);
					if (scan_addr_q == '0) begin
						state_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					state_q <= ST_RES;
				end
				ST_RES: begin
					if (res_load) begin
						state_q <= ST_ACC;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// Sample updates and scan reads never share the memory pipeline
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(acc_vld_s1 && scan_vld_s1))
		else $error("sample update overlaps scan read");

	// The last sample's write-back is done before the sweep starts
	a_drain_before_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !acc_vld_s1)
		else $error("sample write-back pending during scan");

	// A new result appears only from the result state
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_RES))
		else $error("result loaded outside result state");

	// No sample is taken while the memory is being swept
	a_no_accept_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		sweeping |-> !in_ready)
		else $error("input accepted during sweep");
`endif

endmodule
